// File: design/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared codes, constants and the digit-to-segment table for the multiplexed
// seven-segment display driver.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Input transaction kinds
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  // Register map (word index taken from paddr[2])
  localparam logic REG_POINT_POSITION = 1'b0;

  localparam logic [1:0] POINT_POSITION_RESET = 2'd2;

  // Exact floor(x / 10) for any 32-bit x: (x * 0xCCCCCCCD) >> 35
  localparam logic [63:0] DIV10_MULT  = 64'h0000_0000_CCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic [3:0] MAX_DECIMAL_DIGIT = 4'd9;

  // Segment order: bit7 A, bit6 B, bit5 C, bit4 D, bit3 E, bit2 F, bit1 G, bit0 point
  function automatic logic [7:0] seg_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'b1111_1100;
      4'd1:    g = 8'b0110_0000;
      4'd2:    g = 8'b1101_1010;
      4'd3:    g = 8'b1111_0010;
      4'd4:    g = 8'b0110_0110;
      4'd5:    g = 8'b1011_0110;
      4'd6:    g = 8'b1011_1110;
      4'd7:    g = 8'b1110_0000;
      4'd8:    g = 8'b1111_1110;
      4'd9:    g = 8'b1111_0110;
      default: g = 8'b0000_0000;
    endcase
    return g;
  endfunction

endpackage

// File: design/multiplexed_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver
// Scan driver for a multiplexed seven-segment display with decimal loading.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while item_stall is low. A load splits
// its 32-bit value into DIGITS decimal digits, one digit per pipeline stage
// (a reciprocal multiply by one tenth in each), and the digits pass from the
// input register through every stage to the display store; loads give no
// result. A tick follows the same pipeline so that it always sees every
// earlier load, then advances the scan position and presents the digit
// enables and segment pattern. A result waiting in the output register does
// not block the pipeline until all stages are full. point_position is written
// over the APB port (byte address 0) and lights the point on that position.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_driver #(
  parameter int DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        action,
  input  logic [31:0] value,
  // results
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  digit_enable_n,
  output logic [7:0]  segment_lines,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PosW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CmpW = (PosW > 2) ? PosW : 2;
  localparam int DigW = DIGITS * 4;

  // ---------------------------------------------------------------- config
  logic [1:0] point_position;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_position <= msd_pkg::POINT_POSITION_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == msd_pkg::REG_POINT_POSITION) begin
      point_position <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == msd_pkg::REG_POINT_POSITION) begin
      prdata[1:0] = point_position;
    end
  end

  // ----------------------------------------------------------- input stage
  logic        s0_valid;
  logic        s0_action;
  logic [31:0] s0_value;

  logic            pv   [0:DIGITS];
  logic            prdy [0:DIGITS];
  logic            pact [0:DIGITS];
  logic [31:0]     pquot[0:DIGITS-1];
  logic [DigW-1:0] pdig [0:DIGITS];

  assign item_stall = s0_valid && !prdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!item_stall) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s0_action <= action;
      s0_value  <= value;
    end
  end

  assign pv[0]    = s0_valid;
  assign pact[0]  = s0_action;
  assign pquot[0] = s0_value;
  assign pdig[0]  = '0;

  // --------------------------------------------------------- digit stages
  for (genvar s = 0; s < DIGITS; s++) begin : g_stage
    if (s == DIGITS - 1) begin : g_last
      msd_div_stage #(.DIGITS(DIGITS), .STAGE(s)) u_stage (
        .clk       (clk),
        .rst       (rst),
        .up_valid  (pv[s]),
        .up_ready  (prdy[s]),
        .up_action (pact[s]),
        .up_quot   (pquot[s]),
        .up_digits (pdig[s]),
        .dn_valid  (pv[s+1]),
        .dn_ready  (prdy[s+1]),
        .dn_action (pact[s+1]),
        .dn_quot   (),
        .dn_digits (pdig[s+1])
      );
    end else begin : g_mid
      msd_div_stage #(.DIGITS(DIGITS), .STAGE(s)) u_stage (
        .clk       (clk),
        .rst       (rst),
        .up_valid  (pv[s]),
        .up_ready  (prdy[s]),
        .up_action (pact[s]),
        .up_quot   (pquot[s]),
        .up_digits (pdig[s]),
        .dn_valid  (pv[s+1]),
        .dn_ready  (prdy[s+1]),
        .dn_action (pact[s+1]),
        .dn_quot   (pquot[s+1]),
        .dn_digits (pdig[s+1])
      );
    end
  end

  // ---------------------------------------------------------- commit stage
  logic [3:0]      digit_store [DIGITS];
  logic [PosW-1:0] scan_position;
  logic [PosW-1:0] scan_next;
  logic            out_free;
  logic            retire;
  logic            tick_retire;
  logic            load_retire;
  logic [3:0]      cur_digit;
  logic [3:0]      enables_next;
  logic [7:0]      segments_next;

  assign out_free     = !result_valid || !result_stall;
  // loads never occupy the output register, so they retire regardless
  assign prdy[DIGITS] = !(pv[DIGITS] && pact[DIGITS] == msd_pkg::ACTION_TICK) || out_free;
  assign retire       = pv[DIGITS] && prdy[DIGITS];
  assign tick_retire  = retire && pact[DIGITS] == msd_pkg::ACTION_TICK;
  assign load_retire  = retire && pact[DIGITS] == msd_pkg::ACTION_LOAD;

  assign scan_next = (scan_position == PosW'(DIGITS - 1)) ? '0 : scan_position + 1'b1;
  assign cur_digit = digit_store[scan_next];

  always_comb begin
    enables_next = 4'b1111;
    for (int k = 0; k < 4; k++) begin
      if (32'(scan_next) == k) begin
        enables_next[k] = 1'b0;
      end
    end
    segments_next = msd_pkg::seg_glyph(cur_digit);
    if (CmpW'(scan_next) == CmpW'(point_position)) begin
      segments_next[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
      for (int k = 0; k < DIGITS; k++) begin
        digit_store[k] <= '0;
      end
    end else begin
      if (tick_retire) begin
        scan_position <= scan_next;
      end
      if (load_retire) begin
        for (int k = 0; k < DIGITS; k++) begin
          digit_store[k] <= pdig[DIGITS][k*4 +: 4];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tick_retire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_retire) begin
      digit_enable_n <= enables_next;
      segment_lines  <= segments_next;
    end
  end

  // ------------------------------------------------------------ assertions
  logic store_decimal;

  always_comb begin
    store_decimal = 1'b1;
    for (int k = 0; k < DIGITS; k++) begin
      if (digit_store[k] > msd_pkg::MAX_DECIMAL_DIGIT) begin
        store_decimal = 1'b0;
      end
    end
  end

  a_store_decimal: assert property (@(posedge clk) disable iff (rst)
    store_decimal)
    else $error("digit store holds a non-decimal digit");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_position <= PosW'(DIGITS - 1))
    else $error("scan position beyond last digit");

  a_one_enable: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $countones(digit_enable_n) >= 3)
    else $error("more than one digit enabled");

  a_tick_presents: assert property (@(posedge clk) disable iff (rst)
    tick_retire |=> result_valid)
    else $error("retired tick did not reach the output register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s0_valid && pv[DIGITS]))
    else $error("input stalled while pipeline has room");

endmodule

// File: design/msd_div_stage.sv
// ----------------------------------------------------------------------------
// msd_div_stage
// One pipeline stage of the decimal split: divides the running quotient by
// ten and records the remainder as digit STAGE. Tick transactions ride along.
// ----------------------------------------------------------------------------
module msd_div_stage #(
  parameter int DIGITS = 4,
  parameter int STAGE  = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic                  up_action,
  input  logic [31:0]           up_quot,
  input  logic [DIGITS*4-1:0]   up_digits,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic                  dn_action,
  output logic [31:0]           dn_quot,
  output logic [DIGITS*4-1:0]   dn_digits
);

  logic [63:0]         prod;
  logic [31:0]         quot_next;
  logic [3:0]          ten_low;
  logic [3:0]          digit;
  logic [DIGITS*4-1:0] digits_next;

  assign up_ready = !dn_valid || dn_ready;

  assign prod      = 64'(up_quot) * msd_pkg::DIV10_MULT;
  assign quot_next = 32'(prod[63:msd_pkg::DIV10_SHIFT]);

  // remainder is below ten, so only the low nibble of 10*q matters
  assign ten_low = {quot_next[2:0], 1'b0} + {quot_next[0], 3'b000};
  assign digit   = up_quot[3:0] - ten_low;

  always_comb begin
    digits_next = up_digits;
    digits_next[STAGE*4 +: 4] = digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_action <= up_action;
      dn_quot   <= quot_next;
      dn_digits <= digits_next;
    end
  end

endmodule
